FILE: hdl/pci_intx_swizzle_aggregator_defines.svh
// assertion helpers shared by the rtl files
`ifndef PCI_INTX_SWIZZLE_AGGREGATOR_DEFINES_SVH
`define PCI_INTX_SWIZZLE_AGGREGATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PISA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PISA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pisa_pkg.sv
`default_nettype none

package pisa_pkg;

	localparam int unsigned SRC_BITS  = 256;
	localparam int unsigned CNT_W     = $clog2(SRC_BITS + 1);
	localparam int unsigned MASK_BITS = 4;

	localparam logic [7:0] PIN_INTA = 8'd1;
	localparam logic [7:0] PIN_INTD = 8'd4;

	typedef struct packed {
		logic [7:0] source_devfn;
		logic [7:0] intr_pin;
		logic       new_level;
	} in_t;

	typedef struct packed {
		logic [1:0] line_index;
		logic       line_level;
	} out_t;

	// update request from the control stage to the source store
	typedef struct packed {
		logic       wr;
		logic [7:0] devfn;
		logic       level;
	} store_req_t;

endpackage

`default_nettype wire

FILE: hdl/pisa_route.sv
`default_nettype none

module pisa_route #(
	parameter int unsigned NUM_LINES = 4
) (
	input  wire logic [7:0]                            devfn,
	input  wire logic [7:0]                            pin,
	output logic      [(NUM_LINES > 1 ? $clog2(NUM_LINES) : 1)-1:0] line,
	output logic                                       pin_ok
);

	localparam int unsigned LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic [LINE_W-1:0] slot_tab [32];
	logic [LINE_W-1:0] pin_tab [4];
	logic [1:0]        pin_m1;
	logic [LINE_W:0]   sum;

	// residue tables built at elaboration
	for (genvar i = 0; i < 32; i++) begin : g_slot
		localparam logic [LINE_W-1:0] SlotMod = LINE_W'(i % NUM_LINES);
		assign slot_tab[i] = SlotMod;
	end
	for (genvar j = 0; j < 4; j++) begin : g_pin
		localparam logic [LINE_W-1:0] PinMod = LINE_W'(j % NUM_LINES);
		assign pin_tab[j] = PinMod;
	end

	always_comb begin
		pin_ok = (pin >= pisa_pkg::PIN_INTA) && (pin <= pisa_pkg::PIN_INTD);
		pin_m1 = 2'(pin[1:0] - 2'd1);
		sum    = {1'b0, slot_tab[devfn[7:3]]} + {1'b0, pin_tab[pin_m1]};
		if (sum >= (LINE_W + 1)'(NUM_LINES)) begin
			sum = sum - (LINE_W + 1)'(NUM_LINES);
		end
		line = sum[LINE_W-1:0];
	end

endmodule

`default_nettype wire

FILE: hdl/pisa_store.sv
`default_nettype none

`include "pci_intx_swizzle_aggregator_defines.svh"

module pisa_store #(
	parameter int unsigned NUM_LINES = 4
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire pisa_pkg::store_req_t                              req,
	input  wire logic [(NUM_LINES > 1 ? $clog2(NUM_LINES) : 1)-1:0] line,
	output logic                                                   level
);

	localparam int unsigned LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic [pisa_pkg::SRC_BITS-1:0] src_q [NUM_LINES];
	logic [pisa_pkg::CNT_W-1:0]    cnt_q [NUM_LINES];
	logic                          cur_bit;
	logic                          inc;
	logic                          dec;
	logic [pisa_pkg::CNT_W-1:0]    cnt_next;

	// per-line count of asserting sources stands in for the wide or
	always_comb begin
		cur_bit  = src_q[line][req.devfn];
		inc      = req.level & ~cur_bit;
		dec      = ~req.level & cur_bit;
		cnt_next = cnt_q[line] + pisa_pkg::CNT_W'(inc) - pisa_pkg::CNT_W'(dec);
		level    = (cnt_next != '0);
	end

	for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				src_q[g] <= '0;
				cnt_q[g] <= '0;
			end else if (req.wr && (line == LINE_W'(g))) begin
				src_q[g][req.devfn] <= req.level;
				cnt_q[g]            <= cnt_next;
			end
		end

		`PISA_ASSERT_IMPL(a_cnt_matches_set, 1'b1, (cnt_q[g] != '0) == (|src_q[g]), "count and set disagree")
	end

	`PISA_ASSERT_NEXT(a_write_lands, req.wr, src_q[$past(line)][$past(req.devfn)] == $past(req.level), "source bit not updated")

endmodule

`default_nettype wire

FILE: hdl/pci_intx_swizzle_aggregator.sv
`default_nettype none

`include "pci_intx_swizzle_aggregator_defines.svh"

// pci intx swizzle and shared-line level aggregator
// input channel: an event (devfn, interrupt pin, new level) transfers on a
//   rising edge with start high and busy low; busy is always low, so an
//   event may be issued every cycle
// result channel: done pulses for one cycle with result holding the routing
//   line and its aggregated level; the receiver cannot stall and every
//   result transfers in the cycle it is shown
// pipeline: an event is registered in s1, routed and applied to the source
//   store in that cycle, and its result is then registered in the result
//   register; throughput is one event per cycle, set by the read-modify-write
//   of the per-line source set and its asserting count
// events with a pin outside inta..intd change nothing and give no result;
//   events on a line whose bit in the connected mask is clear update the
//   store but give no result
// config channel: cfg_data is the line connected mask, cfg_ready is always
//   high; write it only while no event is in flight
// reset: the source sets, the counts and the mask clear at once, no sweep
module pci_intx_swizzle_aggregator #(
	parameter int unsigned NUM_LINES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pisa_pkg::in_t item,
	output logic               done,
	output pisa_pkg::out_t     result,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [3:0]    cfg_data
);

	localparam int unsigned LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	// input stage
	logic          valid_s1;
	pisa_pkg::in_t item_s1;

	// config
	logic [pisa_pkg::MASK_BITS-1:0] mask_q;

	// result register
	logic           done_q;
	pisa_pkg::out_t result_q;

	// stage logic
	logic                 pin_ok;
	logic [LINE_W-1:0]    line;
	logic [2:0]           line3;
	logic                 connected;
	logic                 new_level;
	pisa_pkg::store_req_t req;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	// capture each start transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// swizzle: (slot + pin - 1) mod NUM_LINES
	pisa_route #(
		.NUM_LINES(NUM_LINES)
	) u_route (
		.devfn (item_s1.source_devfn),
		.pin   (item_s1.intr_pin),
		.line  (line),
		.pin_ok(pin_ok)
	);

	always_comb begin
		req.wr    = valid_s1 && pin_ok;
		req.devfn = item_s1.source_devfn;
		req.level = item_s1.new_level;
		// lines past the mask width never report
		line3     = 3'(line);
		connected = !line3[2] && mask_q[line3[1:0]];
	end

	// set update and new line level in the same cycle
	pisa_store #(
		.NUM_LINES(NUM_LINES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.line  (line),
		.level (new_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.wr && connected;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr && connected) begin
			result_q.line_index <= line3[1:0];
			result_q.line_level <= new_level;
		end
	end

	`PISA_ASSERT_NEXT(a_no_result_without_event, !valid_s1, !done_q, "result without event")
	`PISA_ASSERT_NEXT(a_bad_pin_silent, valid_s1 && !pin_ok, !done_q, "result for ignored pin")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

// self-checking bench for the pci intx swizzle and shared-line aggregator
// - a driver (clocked always block) issues interrupt level events from a queue
//   that the initial block fills phase by phase
// - every accepted event runs through a bench-side copy of the routing and
//   per-line source sets, which queues the line report that should come back
// - a monitor (clocked always block) matches each done pulse against the
//   oldest queued report
// - the connected mask is rewritten only between phases, once the block is quiet
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINES       = 4;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned SEG_ITEMS   = 250;
	localparam int unsigned NUM_SEGS    = 6;
	// settle margin once the queues are empty, covering the s1 and result registers
	localparam int unsigned SETTLE      = 6;

	// pin codes besides the package's inta/intd
	localparam logic [7:0] PIN_NONE = 8'd0;
	localparam logic [7:0] PIN_INTB = pisa_pkg::PIN_INTA + 8'd1;
	localparam logic [7:0] PIN_INTC = pisa_pkg::PIN_INTA + 8'd2;
	localparam logic [7:0] PIN_HIGH = 8'hFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	pisa_pkg::in_t     item = '0;
	logic              done;
	pisa_pkg::out_t    result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [3:0]        cfg_data = 4'h0;

	pci_intx_swizzle_aggregator #(
		.NUM_LINES(LINES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// events waiting to be issued and line reports waiting to come back
	pisa_pkg::in_t  events_pending[$];
	pisa_pkg::out_t line_reports_due[$];

	// bench copy of the block state: one 256-bit source set per routing line
	logic [255:0] asserting_set [LINES];
	logic [3:0]   connected_lines = 4'h0;

	int unsigned send_idle_pct = 23;
	int unsigned mismatches    = 0;
	int unsigned events_taken  = 0;
	int unsigned events_dropped = 0;
	int unsigned reports_seen  = 0;
	int unsigned rising_seen   = 0;
	int unsigned cycles        = 0;
	logic [7:0]  devfn_pool [6];

	initial begin
		for (int i = 0; i < LINES; i++) begin
			asserting_set[i] = '0;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// swizzle the event onto its line, update the line's source set and
	// queue the level report when the line is connected
	task automatic route_and_aggregate(input pisa_pkg::in_t ev);
		int unsigned    line;
		pisa_pkg::out_t rpt;
		if (ev.intr_pin < pisa_pkg::PIN_INTA || ev.intr_pin > pisa_pkg::PIN_INTD) begin
			// pin outside inta..intd: nothing changes, nothing reported
			events_dropped++;
			return;
		end
		line = (int'(ev.source_devfn[7:3]) + int'(ev.intr_pin) - 1) % LINES;
		asserting_set[line][ev.source_devfn] = ev.new_level;
		// lines without a mask bit count as unconnected
		if (line >= pisa_pkg::MASK_BITS || !connected_lines[line])
			return;
		rpt.line_index = line[1:0];
		rpt.line_level = |asserting_set[line];
		line_reports_due.push_back(rpt);
	endtask

	// driver: one start transfer per free slot, random idle cycles in between
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			if (start && !busy) begin
				route_and_aggregate(item);
				events_taken++;
			end
			if (!start || !busy) begin
				if (events_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item  <= events_pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: a done pulse is a transfer that cannot be held off
	always @(posedge clk) begin
		if (arst_n && done) begin
			reports_seen++;
			if (line_reports_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected report line %0d level %0d",
					result.line_index, result.line_level));
			end else begin
				pisa_pkg::out_t want;
				want = line_reports_due.pop_front();
				if (result.line_index !== want.line_index)
					flag_mismatch($sformatf("line_index %0d, want %0d",
						result.line_index, want.line_index));
				if (result.line_level !== want.line_level)
					flag_mismatch($sformatf("line_level %0d, want %0d on line %0d",
						result.line_level, want.line_level, want.line_index));
				if (want.line_level)
					rising_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding",
				cycles, line_reports_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_event(input logic [7:0] devfn, input logic [7:0] pin,
		input logic lvl);
		pisa_pkg::in_t ev;
		ev.source_devfn = devfn;
		ev.intr_pin     = pin;
		ev.new_level    = lvl;
		events_pending.push_back(ev);
	endtask

	// wait until every event is issued and every report is back, then let
	// the pipeline drain events that produce no report
	task automatic wait_quiet();
		do @(posedge clk);
		while (events_pending.size() != 0 || start || line_reports_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_connected_mask(input logic [3:0] mask);
		cfg_valid <= 1'b1;
		cfg_data  <= mask;
		do @(posedge clk);
		while (!cfg_ready);
		connected_lines = mask;
		cfg_valid <= 1'b0;
	endtask

	// mostly valid pins on a small set of functions so shared lines fill up
	// and drain again; the rest is random functions and bad pins
	function automatic pisa_pkg::in_t random_event();
		pisa_pkg::in_t ev;
		if ($urandom_range(99) < 12)
			ev.intr_pin = $urandom_range(1) ? PIN_NONE : 8'($urandom_range(255, 5));
		else
			ev.intr_pin = 8'($urandom_range(4, 1));
		if ($urandom_range(99) < 65)
			ev.source_devfn = devfn_pool[$urandom_range(5)];
		else
			ev.source_devfn = 8'($urandom_range(255));
		ev.new_level = 1'($urandom_range(1));
		return ev;
	endfunction

	initial begin
		logic [3:0] seg_mask [NUM_SEGS];
		seg_mask = '{4'hF, 4'h5, 4'h0, 4'hA, 4'h0, 4'hF};
		seg_mask[4] = 4'($urandom_range(15));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mask still at reset: the set is updated but no report comes back
		queue_event(8'h00, pisa_pkg::PIN_INTA, 1'b1);
		wait_quiet();
		write_connected_mask(4'hF);

		// two functions sharing line 0: slot 0 inta and slot 1 intd
		queue_event(8'h08, pisa_pkg::PIN_INTD, 1'b1);
		queue_event(8'h00, pisa_pkg::PIN_INTA, 1'b0);
		queue_event(8'h08, pisa_pkg::PIN_INTD, 1'b0);
		// repeated deassert and assert
		queue_event(8'h08, pisa_pkg::PIN_INTD, 1'b0);
		queue_event(8'h00, pisa_pkg::PIN_INTA, 1'b1);
		queue_event(8'h00, pisa_pkg::PIN_INTA, 1'b1);
		// each pin from slot 0, one per line
		queue_event(8'h00, PIN_INTB, 1'b1);
		queue_event(8'h00, PIN_INTC, 1'b1);
		queue_event(8'h00, pisa_pkg::PIN_INTD, 1'b1);
		// pins outside inta..intd are ignored
		queue_event(8'h00, PIN_NONE, 1'b0);
		queue_event(8'h00, pisa_pkg::PIN_INTD + 8'd1, 1'b0);
		queue_event(8'hFF, PIN_HIGH, 1'b1);
		// highest devfn and the word boundaries inside a line set
		queue_event(8'hFF, pisa_pkg::PIN_INTD, 1'b1);
		queue_event(8'h3F, pisa_pkg::PIN_INTA, 1'b1);
		queue_event(8'h40, pisa_pkg::PIN_INTA, 1'b1);
		queue_event(8'hC0, PIN_INTC, 1'b1);
		queue_event(8'hFF, pisa_pkg::PIN_INTD, 1'b0);
		queue_event(8'h00, PIN_INTC, 1'b0);
		queue_event(8'hC0, PIN_INTC, 1'b0);
		// back to back on one function
		queue_event(8'h3F, pisa_pkg::PIN_INTA, 1'b0);
		queue_event(8'h3F, pisa_pkg::PIN_INTA, 1'b1);
		wait_quiet();

		// random part: idle rate 23%, then 57%, then none
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			write_connected_mask(seg_mask[seg]);
			send_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 57 : 0;
			for (int p = 0; p < 6; p++)
				devfn_pool[p] = 8'($urandom_range(255));
			for (int n = 0; n < SEG_ITEMS; n++)
				events_pending.push_back(random_event());
			wait_quiet();
		end

		$display("%0d events issued (%0d with bad pins), %0d line reports checked (%0d high)",
			events_taken, events_dropped, reports_seen, rising_seen);
		$display("connected masks used: F,5,0,A,%h,F; sender idle at 23%%, 57%% and 0%%",
			seg_mask[4]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: pci_intx_swizzle_aggregator.f
+incdir+hdl
hdl/pisa_pkg.sv
hdl/pisa_route.sv
hdl/pisa_store.sv
hdl/pci_intx_swizzle_aggregator.sv
tb/tb.sv
